### design/sis_pkg.sv
// Shared types and constants for the sorted index with insertion and search.
// Used by the channel interfaces, the entry RAM user and the top level.
// No dependencies.
`default_nettype none

package sis_pkg;

	// Number of table entries.
	localparam int TABLE_DEPTH = 16;

	// Widths that follow from the table depth.
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	// Signed bound width for the search window, one sign bit above the count.
	localparam int BND_W = CNT_W + 1;

	// Fixed field widths of the channels.
	localparam int KEY_W  = 64;
	localparam int ADDR_W = 16;
	localparam int POS_W  = 4;

	// Request type codes.
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_FOUND     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic              req_type;
		logic [KEY_W-1:0]  entry_key;
		logic [ADDR_W-1:0] record_addr;
	} req_item_t;

	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  position;
		logic [ADDR_W-1:0] found_addr;
	} rsp_item_t;

	// One stored table entry.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SHIFT,
		ST_INS_PLACE,
		ST_SRCH_PROBE,
		ST_SRCH_CMP,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

### design/sis_req_if.sv
// Request channel: valid/ready handshake carrying one request item.
// Depends on sis_pkg for the payload type.
`default_nettype none

interface sis_req_if;
	logic                  valid;
	logic                  ready;
	sis_pkg::req_item_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/sis_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
// Depends on sis_pkg for the payload type.
`default_nettype none

interface sis_rsp_if;
	logic                  valid;
	logic                  ready;
	sis_pkg::rsp_item_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/sorted_index_insert_search.sv
// Top level of the sorted key index: insertion with shifting, binary search.
// Depends on sis_pkg, sis_req_if, sis_rsp_if and sis_ram.
//
// Usage. Requests arrive on the req channel and each one produces exactly one
// result on the rsp channel; a transfer happens on a clock edge where valid
// and ready are both high. An insert request places entry_key with its
// record_addr into the table, after every stored entry with an equal key, and
// reports the position; when the table already holds TABLE_DEPTH entries it
// reports table full and changes nothing. A search request runs a binary
// search over the filled part and reports the first probed match with its
// stored address, or not found.
//
// Timing. The block works on one request at a time and holds req.ready low
// until that request's result sits in the output register. All table access
// goes through a single RAM with one write and one registered read port, so
// one entry moves per cycle. An insert shifts each stored entry with a
// greater key up one slot, then places the new entry and finishes; an insert
// into an empty table places at once, and one refused on a full table goes
// straight to finishing. Each search probe reads the middle entry of the
// window and then compares it, until a match or an empty window. The next
// request can be accepted in the same cycle as the result appears.
//
// Reset clears the entry count and the control state; the table contents
// are not cleared, since only entries below the count are ever read. A
// result waiting in the output register does not block the next request: it
// is only the finishing step of that next request that waits for the
// register to drain when the receiver stalls.
`default_nettype none

module sorted_index_insert_search (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sis_req_if.sink    req,
	sis_rsp_if.source  rsp
);

	localparam int ENTRY_W = $bits(sis_pkg::entry_t);

	// Control state.
	sis_pkg::state_t              state_q, state_n;
	logic [sis_pkg::CNT_W-1:0]    cnt_q, cnt_n;
	logic                         out_valid_q;

	// Request captured at acceptance.
	logic [sis_pkg::KEY_W-1:0]    key_q;
	logic [sis_pkg::ADDR_W-1:0]   addr_q;

	// Insertion slot, and the search window with its current probe.
	logic [sis_pkg::IDX_W-1:0]    slot_q, slot_n;
	logic signed [sis_pkg::BND_W-1:0] low_q, low_n, high_q, high_n;
	logic [sis_pkg::IDX_W-1:0]    mid_q, mid_n;

	// Result waiting to go to the output register, and the output register.
	sis_pkg::rsp_item_t           res_q, res_n;
	sis_pkg::rsp_item_t           out_q;

	// Entry RAM port.
	logic                         ram_we;
	logic [sis_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
	sis_pkg::entry_t              ram_wdata, ram_rdata;

	logic                         req_fire;
	logic                         out_free;
	logic                         key_lt_probe;
	logic                         key_eq_probe;
	logic                         win_empty;
	logic [sis_pkg::BND_W:0]      win_sum;
	logic [sis_pkg::IDX_W-1:0]    win_mid;

	sis_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (sis_pkg::TABLE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready   = (state_q == sis_pkg::ST_IDLE);
	assign req_fire    = req.valid && req.ready;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;
	assign out_free    = !out_valid_q || rsp.ready;

	// Key comparisons against the read entry; the less-than result is shared by the shift loop and the search probes.
	assign key_lt_probe = key_q < ram_rdata.key;
	assign key_eq_probe = key_q == ram_rdata.key;

	// Search window: empty when the low bound passes the high bound. Both
	// bounds are non-negative whenever the window is not empty.
	assign win_empty = low_q > high_q;
	assign win_sum   = (sis_pkg::BND_W + 1)'($unsigned(low_q))
		+ (sis_pkg::BND_W + 1)'($unsigned(high_q));
	assign win_mid   = win_sum[sis_pkg::IDX_W:1];

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			sis_pkg::ST_IDLE: begin
				if (req_fire) begin
					if (req.payload.req_type == sis_pkg::REQ_SEARCH) begin
						state_n = sis_pkg::ST_SRCH_PROBE;
					end else if (cnt_q == sis_pkg::CNT_W'(sis_pkg::TABLE_DEPTH)) begin
						state_n = sis_pkg::ST_FINISH;
					end else if (cnt_q == '0) begin
						state_n = sis_pkg::ST_INS_PLACE;
					end else begin
						state_n = sis_pkg::ST_INS_SHIFT;
					end
				end
			end
			sis_pkg::ST_INS_SHIFT: begin
				if (!key_lt_probe || slot_q == sis_pkg::IDX_W'(1)) begin
					state_n = sis_pkg::ST_INS_PLACE;
				end
			end
			sis_pkg::ST_INS_PLACE: begin
				state_n = sis_pkg::ST_FINISH;
			end
			sis_pkg::ST_SRCH_PROBE: begin
				state_n = win_empty ? sis_pkg::ST_FINISH : sis_pkg::ST_SRCH_CMP;
			end
			sis_pkg::ST_SRCH_CMP: begin
				state_n = key_eq_probe ? sis_pkg::ST_FINISH : sis_pkg::ST_SRCH_PROBE;
			end
			sis_pkg::ST_FINISH: begin
				if (out_free) begin
					state_n = sis_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = sis_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath controls: RAM port, slot, window, count and result.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = ram_rdata;
		ram_raddr = mid_q;
		slot_n    = slot_q;
		low_n     = low_q;
		high_n    = high_q;
		mid_n     = mid_q;
		cnt_n     = cnt_q;
		res_n     = res_q;
		unique case (state_q)
			sis_pkg::ST_IDLE: begin
				// Start reading the last entry so the shift loop can compare
				// against it on the next cycle.
				slot_n    = cnt_q[sis_pkg::IDX_W-1:0];
				ram_raddr = cnt_q[sis_pkg::IDX_W-1:0] - sis_pkg::IDX_W'(1);
				low_n     = '0;
				high_n    = $signed({1'b0, cnt_q}) - sis_pkg::BND_W'(1);
				res_n     = '{status: sis_pkg::STAT_FULL, position: '0, found_addr: '0};
			end
			sis_pkg::ST_INS_SHIFT: begin
				// A strictly greater entry moves up one slot; the read of
				// the next lower entry is issued in the same cycle.
				if (key_lt_probe) begin
					ram_we    = 1'b1;
					ram_waddr = slot_q;
					ram_wdata = ram_rdata;
					slot_n    = slot_q - sis_pkg::IDX_W'(1);
					ram_raddr = slot_q - sis_pkg::IDX_W'(2);
				end
			end
			sis_pkg::ST_INS_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = '{key: key_q, addr: addr_q};
				cnt_n     = cnt_q + sis_pkg::CNT_W'(1);
				res_n     = '{status: sis_pkg::STAT_INSERTED,
					position: sis_pkg::POS_W'(slot_q), found_addr: '0};
			end
			sis_pkg::ST_SRCH_PROBE: begin
				ram_raddr = win_mid;
				mid_n     = win_mid;
				res_n     = '{status: sis_pkg::STAT_NOT_FOUND, position: '0,
					found_addr: '0};
			end
			sis_pkg::ST_SRCH_CMP: begin
				if (key_eq_probe) begin
					res_n = '{status: sis_pkg::STAT_FOUND,
						position: sis_pkg::POS_W'(mid_q), found_addr: ram_rdata.addr};
				end else if (key_lt_probe) begin
					high_n = $signed({1'b0, sis_pkg::CNT_W'(mid_q)}) - sis_pkg::BND_W'(1);
				end else begin
					low_n = $signed({1'b0, sis_pkg::CNT_W'(mid_q)}) + sis_pkg::BND_W'(1);
				end
			end
			sis_pkg::ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sis_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			if (state_q == sis_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			key_q  <= req.payload.entry_key;
			addr_q <= req.payload.record_addr;
		end
		slot_q <= slot_n;
		low_q  <= low_n;
		high_q <= high_n;
		mid_q  <= mid_n;
		res_q  <= res_n;
		if (state_q == sis_pkg::ST_FINISH && out_free) begin
			out_q <= res_q;
		end
	end

	// The entry count never goes beyond the table depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sis_pkg::CNT_W'(sis_pkg::TABLE_DEPTH))
		else $error("entry count above table depth");

	// The table is written only while an insert shifts or places an entry.
	a_write_in_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == sis_pkg::ST_INS_SHIFT || state_q == sis_pkg::ST_INS_PLACE))
		else $error("table written outside an insert");

	// Placing an entry raises the count by exactly one.
	a_place_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sis_pkg::ST_INS_PLACE |=> cnt_q == $past(cnt_q) + sis_pkg::CNT_W'(1))
		else $error("insert did not advance the entry count");

	// A search probe always lies inside the filled part of the table.
	a_probe_filled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sis_pkg::ST_SRCH_CMP |-> sis_pkg::CNT_W'(mid_q) < cnt_q)
		else $error("search probe outside the filled entries");

	// A new result is loaded only when the previous one has been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sis_pkg::ST_FINISH && out_valid_q && !rsp.ready) |=> state_q == sis_pkg::ST_FINISH)
		else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

### design/sis_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
